/* hw/rtl/bmpbr_pkg.sv */
// Shared types and constants for the BMP 24-bit brightness stream.
// Used by every module under hw/rtl; no dependencies.
package bmpbr_pkg;

	localparam int HEADER_BYTES    = 14;
	localparam int CORE_INFO_BYTES = 12;
	localparam int WIDTH_BITS      = 16;
	localparam int RCW             = WIDTH_BITS + 2;
	localparam int MIN_INFO        = 4;
	localparam int FIELD_BYTES     = 4;
	localparam int DOFF_POS        = 10;
	localparam int INFO_WIDTH_OFS  = 'h04;
	localparam int CORE_BPP_OFS    = 'h0A;
	localparam int INFO_BPP_OFS    = 'h0E;
	localparam int INFO_COMP_OFS   = 'h10;
	localparam int BPP_TRUE        = 24;
	localparam logic [15:0] BMP_MAGIC = 16'h4d42;
	localparam int QDEPTH          = 2;
	localparam int QPTR_W          = $clog2(QDEPTH);
	localparam int QCNT_W          = $clog2(QDEPTH + 1);

	typedef enum logic [2:0] {
		ST_HEADER     = 3'd0,
		ST_PIXEL      = 3'd1,
		ST_PADDING    = 3'd2,
		ST_NOT_BMP    = 3'd3,
		ST_NOT_24     = 3'd4,
		ST_TABLE      = 3'd5,
		ST_COMPRESSED = 3'd6,
		ST_TOO_WIDE   = 3'd7
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		status_t    status;
		logic       last_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		status_t    status;
		logic       last;
	} work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* hw/rtl/bmpbr_front.sv */
// Front end: header capture, file check and row tracking per item.
// Depends on bmpbr_pkg; feeds bmpbr_queue.
module bmpbr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bmpbr_pkg::in_item_t in_item,
	input  bmpbr_pkg::q_stat_t  q_stat,
	output logic                push,
	output bmpbr_pkg::work_t    push_item
);

	logic [31:0] pos_q;
	logic [15:0] magic_q;
	logic [31:0] doff_q;
	logic [31:0] info_q;
	logic [31:0] width_q;
	logic [15:0] bpp_q;
	logic [31:0] comp_q;
	logic [bmpbr_pkg::RCW-1:0] rc_q;
	bmpbr_pkg::status_t verdict_q;

	logic        core;
	logic [31:0] info_eff;
	logic [32:0] hdr_end;
	logic        in_hdr;
	logic [31:0] w_ext;
	logic [31:0] enc;
	logic [31:0] rel;
	bmpbr_pkg::status_t judged;
	bmpbr_pkg::status_t verdict_now;
	bmpbr_pkg::status_t st;
	logic [bmpbr_pkg::WIDTH_BITS-1:0] w_n;
	logic [bmpbr_pkg::RCW-1:0] pix;
	logic [bmpbr_pkg::RCW-1:0] row;
	logic [bmpbr_pkg::RCW-1:0] rc_inc;
	logic        rc_step;
	logic        hit_magic, hit_doff, hit_info, hit_width, hit_bpp, hit_comp;
	logic [1:0]  doff_lane;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	assign core     = (info_q == 32'(bmpbr_pkg::CORE_INFO_BYTES));
	assign info_eff = (info_q < 32'(bmpbr_pkg::MIN_INFO)) ? 32'(bmpbr_pkg::MIN_INFO) : info_q;
	assign hdr_end  = 33'(bmpbr_pkg::HEADER_BYTES) + {1'b0, info_eff};
	assign in_hdr   = (verdict_q == bmpbr_pkg::ST_HEADER) && ({1'b0, pos_q} < hdr_end);
	assign w_ext    = core ? {{16{width_q[15]}}, width_q[15:0]} : width_q;
	assign enc      = core ? 32'd0 : comp_q;
	assign rel      = pos_q - 32'(bmpbr_pkg::HEADER_BYTES);
	assign w_n      = w_ext[bmpbr_pkg::WIDTH_BITS-1:0];
	assign pix      = {2'b00, w_n} + {1'b0, w_n, 1'b0};
	assign row      = (pix + bmpbr_pkg::RCW'(bmpbr_pkg::FIELD_BYTES - 1))
		& ~bmpbr_pkg::RCW'(bmpbr_pkg::FIELD_BYTES - 1);
	assign rc_inc   = rc_q + bmpbr_pkg::RCW'(1);
	assign doff_lane = 2'(pos_q - 32'(bmpbr_pkg::DOFF_POS));

	always_comb begin
		if (magic_q != bmpbr_pkg::BMP_MAGIC)
			judged = bmpbr_pkg::ST_NOT_BMP;
		else if (bpp_q != 16'(bmpbr_pkg::BPP_TRUE))
			judged = bmpbr_pkg::ST_NOT_24;
		else if ({1'b0, doff_q} != hdr_end)
			judged = bmpbr_pkg::ST_TABLE;
		else if (enc != 32'd0)
			judged = bmpbr_pkg::ST_COMPRESSED;
		else if ((w_ext >> bmpbr_pkg::WIDTH_BITS) != 32'd0)
			judged = bmpbr_pkg::ST_TOO_WIDE;
		else
			judged = bmpbr_pkg::ST_PIXEL;
	end

	always_comb begin
		verdict_now = (verdict_q == bmpbr_pkg::ST_HEADER) ? judged : verdict_q;
		rc_step = 1'b0;
		if (in_hdr) begin
			st = bmpbr_pkg::ST_HEADER;
		end else if (verdict_now == bmpbr_pkg::ST_PIXEL) begin
			if (w_n == '0) begin
				st = bmpbr_pkg::ST_PADDING;
			end else begin
				rc_step = 1'b1;
				st = (rc_q < pix) ? bmpbr_pkg::ST_PIXEL : bmpbr_pkg::ST_PADDING;
			end
		end else begin
			st = verdict_now;
		end
	end

	always_comb begin
		hit_magic = pos_q < 32'd2;
		hit_doff  = pos_q >= 32'(bmpbr_pkg::DOFF_POS)
			&& pos_q < 32'(bmpbr_pkg::HEADER_BYTES);
		hit_info  = 1'b0;
		hit_width = 1'b0;
		hit_bpp   = 1'b0;
		hit_comp  = 1'b0;
		if (pos_q >= 32'(bmpbr_pkg::HEADER_BYTES)) begin
			hit_info  = rel < 32'(bmpbr_pkg::INFO_WIDTH_OFS);
			hit_width = rel >= 32'(bmpbr_pkg::INFO_WIDTH_OFS)
				&& (rel < 32'(bmpbr_pkg::INFO_WIDTH_OFS + 2)
				|| (!core && rel < 32'(bmpbr_pkg::INFO_WIDTH_OFS + 4)));
			hit_bpp   = core
				? (rel == 32'(bmpbr_pkg::CORE_BPP_OFS) || rel == 32'(bmpbr_pkg::CORE_BPP_OFS + 1))
				: (rel == 32'(bmpbr_pkg::INFO_BPP_OFS) || rel == 32'(bmpbr_pkg::INFO_BPP_OFS + 1));
			hit_comp  = !core && rel >= 32'(bmpbr_pkg::INFO_COMP_OFS)
				&& rel < 32'(bmpbr_pkg::INFO_COMP_OFS + 4);
		end
	end

	always_comb begin
		push_item.data_byte = in_item.data_byte;
		push_item.status    = st;
		push_item.last      = in_item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			magic_q   <= '0;
			doff_q    <= '0;
			info_q    <= '0;
			width_q   <= '0;
			bpp_q     <= '0;
			comp_q    <= '0;
			rc_q      <= '0;
			verdict_q <= bmpbr_pkg::ST_HEADER;
		end else if (push) begin
			if (in_item.last_byte) begin
				pos_q     <= '0;
				magic_q   <= '0;
				doff_q    <= '0;
				info_q    <= '0;
				width_q   <= '0;
				bpp_q     <= '0;
				comp_q    <= '0;
				rc_q      <= '0;
				verdict_q <= bmpbr_pkg::ST_HEADER;
			end else begin
				if (pos_q != '1)
					pos_q <= pos_q + 32'd1;
				if (in_hdr) begin
					if (hit_magic)
						magic_q[{pos_q[0], 3'b000} +: 8] <= in_item.data_byte;
					else if (hit_doff)
						doff_q[{doff_lane, 3'b000} +: 8] <= in_item.data_byte;
					if (hit_info)
						info_q[{rel[1:0], 3'b000} +: 8] <= in_item.data_byte;
					else if (hit_width)
						width_q[{rel[1:0], 3'b000} +: 8] <= in_item.data_byte;
					else if (hit_bpp)
						bpp_q[{rel[0], 3'b000} +: 8] <= in_item.data_byte;
					else if (hit_comp)
						comp_q[{rel[1:0], 3'b000} +: 8] <= in_item.data_byte;
				end else begin
					verdict_q <= verdict_now;
					if (rc_step)
						rc_q <= (rc_inc >= row) ? '0 : rc_inc;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		push && in_item.last_byte |=> pos_q == '0 && verdict_q == bmpbr_pkg::ST_HEADER)
		else $error("file state not cleared after last item");
	a_rc_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_q == bmpbr_pkg::ST_PIXEL && w_n != '0 |-> rc_q < row)
		else $error("row column beyond row length");
	a_pixel_pass: assert property (@(posedge clk) disable iff (!arst_n)
		push && !in_item.last_byte && st == bmpbr_pkg::ST_PIXEL
		|=> verdict_q == bmpbr_pkg::ST_PIXEL)
		else $error("pixel item without passing verdict");
`endif

endmodule

/* hw/rtl/bmpbr_queue.sv */
// Two-entry queue between the front end and the back end.
// Depends on bmpbr_pkg.
module bmpbr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bmpbr_pkg::work_t   push_item,
	input  logic               pop,
	output bmpbr_pkg::work_t   head,
	output bmpbr_pkg::q_stat_t q_stat
);

	bmpbr_pkg::work_t mem_q [bmpbr_pkg::QDEPTH];
	logic [bmpbr_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bmpbr_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bmpbr_pkg::QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == bmpbr_pkg::QCNT_W'(bmpbr_pkg::QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + bmpbr_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + bmpbr_pkg::QPTR_W'(1);
			if (push && !pop)
				count_q <= count_q + bmpbr_pkg::QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - bmpbr_pkg::QCNT_W'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("pop from empty queue");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("push into full queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bmpbr_pkg::QCNT_W'(bmpbr_pkg::QDEPTH))
		else $error("queue count out of range");
`endif

endmodule

/* hw/rtl/bmpbr_back.sv */
// Back end: brightness offset register, saturating add and output register.
// Depends on bmpbr_pkg; drains bmpbr_queue.
module bmpbr_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic signed [8:0]    cfg_wr_data,
	input  bmpbr_pkg::q_stat_t   q_stat,
	input  bmpbr_pkg::work_t     head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bmpbr_pkg::out_item_t out_item
);

	logic signed [8:0] offset_q;
	logic              out_valid_q;
	bmpbr_pkg::out_item_t out_item_q;
	logic              load;
	logic signed [9:0] sum;
	logic [7:0]        sat;

	assign load = !out_valid_q || !out_stall;
	assign pop  = load && !q_stat.empty;
	assign sum  = $signed({2'b00, head.data_byte}) + $signed({offset_q[8], offset_q});

	always_comb begin
		if (sum[9])
			sat = 8'd0;
		else if (sum[8])
			sat = 8'hFF;
		else
			sat = sum[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en)
				offset_q <= cfg_wr_data;
			if (load)
				out_valid_q <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q.out_byte <= (head.status == bmpbr_pkg::ST_PIXEL) ? sat : head.data_byte;
			out_item_q.status   <= head.status;
			out_item_q.last_out <= head.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef NO_ASSERTIONS
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q)
		else $error("popped item not presented");
	a_pass_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.status != bmpbr_pkg::ST_PIXEL |=> out_item_q.out_byte == $past(head.data_byte))
		else $error("non-pixel byte altered");
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !pop)
		else $error("pop while output stalled");
`endif

endmodule

/* hw/rtl/bmp24_brightness_stream_core.sv */
// A byte accepted at the input is written into a queue entry, then into the output register, where it is presented.
// Throughput: one byte per clock while out_stall is low, held by the two-entry queue and the output register.
// Input stalls only while the queue is full; the front stage never stalls the input by itself.
// Reset (arst_n low, asynchronous) clears file state, queue, output valid and sets
// the brightness offset to zero.
module bmp24_brightness_stream_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  bmpbr_pkg::in_item_t  in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output bmpbr_pkg::out_item_t out_item,
	input  logic                 cfg_wr_en,
	input  logic signed [8:0]    cfg_wr_data
);

	logic               push;
	logic               pop;
	bmpbr_pkg::work_t   push_item;
	bmpbr_pkg::work_t   head;
	bmpbr_pkg::q_stat_t q_stat;

	bmpbr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.q_stat    (q_stat),
		.push      (push),
		.push_item (push_item)
	);

	bmpbr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	bmpbr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule

/* tb/sv/bmp24_brightness_stream_core_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bmp24_brightness_stream_core: whole BMP files in, one byte out per byte.
// Depends on bmpbr_pkg and the core; predicts header capture, verdict and brightness saturation.
module bmp24_brightness_stream_core_tb;
	import bmpbr_pkg::*;

	localparam int IDLE_PCT     = 29;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 110;

	typedef struct packed {
		logic [15:0]       magic;
		logic [31:0]       isize;
		logic [31:0]       width;
		logic [15:0]       bpp;
		logic [31:0]       comp;
		logic [31:0]       doff;
		int                info_len;
		int                n_data;
		int                n_send;
		logic signed [8:0] bright;
		bit                typed;
		status_t           want;
	} bmp_case_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	in_item_t          in_item = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_item_t         out_item;
	logic              cfg_wr_en = 1'b0;
	logic signed [8:0] cfg_wr_data = '0;

	// predicted file state
	logic signed [8:0] brightness = '0;
	logic [31:0]       f_pos, f_doff, f_isize, f_width, f_comp;
	logic [15:0]       f_magic, f_bpp;
	longint            f_col;
	status_t           f_verdict;

	out_item_t   outstanding_bytes[$];
	logic [7:0]  file_bytes[$];
	bmp_case_t   dir_cases [13];
	out_item_t   oldest;
	bit          steady = 1'b0;
	int          hold_asks = 0, holds_done = 0, hold_left = 0;
	int          errors = 0, items_sent = 0, files_sent = 0, settings_used = 0, compared = 0;

	bmp24_brightness_stream_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #6 clk = ~clk;

	function automatic void clear_file();
		f_pos = '0;
		f_magic = '0;
		f_doff = '0;
		f_isize = '0;
		f_width = '0;
		f_bpp = '0;
		f_comp = '0;
		f_col = 0;
		f_verdict = ST_HEADER;
	endfunction

	function automatic longint header_limit();
		return HEADER_BYTES + ((f_isize < MIN_INFO) ? longint'(MIN_INFO) : longint'(f_isize));
	endfunction

	function automatic longint image_cols();
		if (f_isize == CORE_INFO_BYTES)
			return longint'($signed(f_width[15:0]));
		return longint'($signed(f_width));
	endfunction

	function automatic void capture_header_byte(logic [31:0] p, logic [7:0] b);
		bit          core;
		int unsigned i;
		core = (f_isize == CORE_INFO_BYTES);
		if (p < 2)
			f_magic[8*p +: 8] = b;
		else if (p >= DOFF_POS && p < DOFF_POS + FIELD_BYTES)
			f_doff[8*(p - DOFF_POS) +: 8] = b;
		if (p < HEADER_BYTES)
			return;
		i = p - HEADER_BYTES;
		if (i < FIELD_BYTES)
			f_isize[8*i +: 8] = b;
		else if (i < INFO_WIDTH_OFS + 2 || (!core && i < INFO_WIDTH_OFS + FIELD_BYTES))
			f_width[8*(i - INFO_WIDTH_OFS) +: 8] = b;
		else if (core && (i == CORE_BPP_OFS || i == CORE_BPP_OFS + 1))
			f_bpp[8*(i - CORE_BPP_OFS) +: 8] = b;
		else if (!core && (i == INFO_BPP_OFS || i == INFO_BPP_OFS + 1))
			f_bpp[8*(i - INFO_BPP_OFS) +: 8] = b;
		else if (!core && i >= INFO_COMP_OFS && i < INFO_COMP_OFS + FIELD_BYTES)
			f_comp[8*(i - INFO_COMP_OFS) +: 8] = b;
	endfunction

	function automatic status_t image_verdict();
		longint      w;
		logic [31:0] enc;
		w = image_cols();
		enc = (f_isize == CORE_INFO_BYTES) ? '0 : f_comp;
		if (f_magic != BMP_MAGIC)
			return ST_NOT_BMP;
		if (f_bpp != BPP_TRUE)
			return ST_NOT_24;
		if (longint'(f_doff) != header_limit())
			return ST_TABLE;
		if (enc != 0)
			return ST_COMPRESSED;
		if (w < 0 || w >= (longint'(1) << WIDTH_BITS))
			return ST_TOO_WIDE;
		return ST_PIXEL;
	endfunction

	function automatic out_item_t next_out_item(in_item_t it);
		out_item_t r;
		longint    w, pix, row;
		int        v;
		r.out_byte = it.data_byte;
		r.last_out = it.last_byte;
		if (f_verdict == ST_HEADER && longint'(f_pos) < header_limit()) begin
			capture_header_byte(f_pos, it.data_byte);
			r.status = ST_HEADER;
		end else begin
			if (f_verdict == ST_HEADER)
				f_verdict = image_verdict();
			if (f_verdict == ST_PIXEL) begin
				w = image_cols();
				pix = 3 * w;
				row = (pix + 3) / 4 * 4;
				if (w == 0) begin
					r.status = ST_PADDING;
				end else begin
					if (f_col < pix) begin
						v = int'(it.data_byte) + int'(brightness);
						if (v > 255)
							v = 255;
						if (v < 0)
							v = 0;
						r.out_byte = v[7:0];
						r.status = ST_PIXEL;
					end else begin
						r.status = ST_PADDING;
					end
					f_col++;
					if (f_col >= row)
						f_col = 0;
				end
			end else begin
				r.status = f_verdict;
			end
		end
		if (f_pos != '1)
			f_pos++;
		if (it.last_byte)
			clear_file();
		return r;
	endfunction

	function automatic logic [7:0] any_byte();
		// bias towards the saturation extremes
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void build_file(bmp_case_t c);
		bit core;
		int total;
		core = (c.isize == CORE_INFO_BYTES);
		file_bytes.delete();
		for (int k = 0; k < HEADER_BYTES; k++) begin
			if (k < 2)
				file_bytes.push_back(c.magic[8*k +: 8]);
			else if (k >= DOFF_POS)
				file_bytes.push_back(c.doff[8*(k - DOFF_POS) +: 8]);
			else
				file_bytes.push_back(8'($urandom_range(255)));
		end
		for (int k = 0; k < c.info_len; k++) begin
			if (k < FIELD_BYTES)
				file_bytes.push_back(c.isize[8*k +: 8]);
			else if (k < INFO_WIDTH_OFS + (core ? 2 : FIELD_BYTES))
				file_bytes.push_back(c.width[8*(k - INFO_WIDTH_OFS) +: 8]);
			else if (core && (k == CORE_BPP_OFS || k == CORE_BPP_OFS + 1))
				file_bytes.push_back(c.bpp[8*(k - CORE_BPP_OFS) +: 8]);
			else if (!core && (k == INFO_BPP_OFS || k == INFO_BPP_OFS + 1))
				file_bytes.push_back(c.bpp[8*(k - INFO_BPP_OFS) +: 8]);
			else if (!core && k >= INFO_COMP_OFS && k < INFO_COMP_OFS + FIELD_BYTES)
				file_bytes.push_back(c.comp[8*(k - INFO_COMP_OFS) +: 8]);
			else
				file_bytes.push_back(8'($urandom_range(255)));
		end
		for (int k = 0; k < c.n_data; k++)
			file_bytes.push_back(any_byte());
		total = file_bytes.size();
		if (c.n_send > 0 && c.n_send < total)
			total = c.n_send;
		while (file_bytes.size() > total)
			void'(file_bytes.pop_back());
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t fixed);
		out_item_t pred;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!steady && $urandom_range(99) < IDLE_PCT);
		end
		in_item <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = next_out_item(it);
		outstanding_bytes.push_back(typed ? fixed : pred);
		items_sent++;
	endtask

	task automatic send_file(input bmp_case_t c);
		in_item_t  it;
		out_item_t fixed;
		build_file(c);
		for (int k = 0; k < file_bytes.size(); k++) begin
			it.data_byte = file_bytes[k];
			it.last_byte = (k == file_bytes.size() - 1);
			fixed.out_byte = it.data_byte;
			fixed.status = (k < HEADER_BYTES + c.info_len) ? ST_HEADER : c.want;
			fixed.last_out = it.last_byte;
			send_item(it, c.typed, fixed);
		end
		files_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (outstanding_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_brightness(input logic signed [8:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		brightness = v;
		settings_used++;
	endtask

	function automatic bmp_case_t random_case();
		bmp_case_t c;
		int        pick, sz, lim;
		pick = $urandom_range(99);
		sz = $urandom_range(9);
		c.isize = (sz < 5) ? 32'd12 : (sz < 7) ? 32'd20 : (sz == 7) ? 32'd16 :
			(sz == 8) ? 32'd40 : 32'd108;
		c.magic = BMP_MAGIC;
		c.bpp = BPP_TRUE;
		c.comp = '0;
		c.width = $urandom_range(0, 6);
		if ($urandom_range(15) == 0)
			c.width = (c.isize == CORE_INFO_BYTES) ? 32'h7FFF : 32'hFFFF;
		c.doff = HEADER_BYTES + c.isize;
		c.info_len = c.isize;
		lim = (c.width > 6) ? 40 : int'((3 * c.width + 3) / 4 * 4) * 2 + 4;
		c.n_data = $urandom_range(0, lim);
		c.n_send = 0;
		c.bright = '0;
		c.typed = 1'b0;
		c.want = ST_HEADER;
		if (pick >= 70 && pick < 90) begin
			case ($urandom_range(6))
				0: c.magic = 16'($urandom);
				1: c.bpp = 16'($urandom);
				2: c.doff = $urandom_range(0, 80);
				3: c.comp = $urandom;
				4: c.width = $urandom | 32'h8000_8000;
				5: c.isize = $urandom_range(1) ? 32'($urandom_range(0, 11)) : $urandom;
				default: c.info_len = $urandom_range(FIELD_BYTES, c.info_len + 8);
			endcase
		end else if (pick >= 90) begin
			if ($urandom_range(1))
				c.magic = 16'($urandom);
			c.n_send = $urandom_range(1, 30);
		end
		return c;
	endfunction

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (holds_done != hold_asks) begin
			holds_done <= hold_asks;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (outstanding_bytes.size() == 0) begin
				$error("unexpected item: out_byte %0d status %0d last_out %0d",
					out_item.out_byte, out_item.status, out_item.last_out);
				errors++;
			end else begin
				oldest = outstanding_bytes.pop_front();
				compared++;
				if (out_item.out_byte !== oldest.out_byte) begin
					$error("out_byte expected %0d got %0d", oldest.out_byte, out_item.out_byte);
					errors++;
				end
				if (out_item.status !== oldest.status) begin
					$error("status expected %0d got %0d", oldest.status, out_item.status);
					errors++;
				end
				if (out_item.last_out !== oldest.last_out) begin
					$error("last_out expected %0d got %0d", oldest.last_out, out_item.last_out);
					errors++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int file_no, start_items, level;
		// magic, isize, width, bpp, comp, doff, info_len, n_data, n_send, bright, typed, want
		dir_cases = '{
			'{BMP_MAGIC, 32'd12, 32'd1, 16'd24, 32'd0, 32'd26, 12, 8, 0, 9'sd0, 1'b0, ST_PIXEL},
			'{BMP_MAGIC, 32'd40, 32'd2, 16'd24, 32'd0, 32'd54, 40, 0, 5, 9'sd0, 1'b1, ST_HEADER},
			'{16'h424d, 32'd12, 32'd2, 16'd24, 32'd0, 32'd26, 12, 3, 0, 9'sd0, 1'b1, ST_NOT_BMP},
			'{BMP_MAGIC, 32'd12, 32'd2, 16'd8, 32'd0, 32'd26, 12, 3, 0, 9'sd0, 1'b1, ST_NOT_24},
			'{BMP_MAGIC, 32'd12, 32'd2, 16'd24, 32'd0, 32'd30, 12, 3, 0, 9'sd0, 1'b1, ST_TABLE},
			'{BMP_MAGIC, 32'd20, 32'd2, 16'd24, 32'd1, 32'd34, 20, 3, 0, 9'sd0, 1'b1,
				ST_COMPRESSED},
			'{BMP_MAGIC, 32'd20, 32'h10000, 16'd24, 32'd0, 32'd34, 20, 3, 0, 9'sd0, 1'b1,
				ST_TOO_WIDE},
			'{BMP_MAGIC, 32'd12, 32'hFFFF, 16'd24, 32'd0, 32'd26, 12, 3, 0, 9'sd0, 1'b1,
				ST_TOO_WIDE},
			'{BMP_MAGIC, 32'd12, 32'd0, 16'd24, 32'd0, 32'd26, 12, 3, 0, 9'sd0, 1'b1, ST_PADDING},
			'{BMP_MAGIC, 32'd2, 32'd0, 16'd24, 32'd0, 32'd18, 4, 4, 0, 9'sd0, 1'b1, ST_NOT_24},
			'{BMP_MAGIC, 32'd16, 32'd3, 16'd24, 32'd7, 32'd30, 16, 14, 0, 9'sd255, 1'b0, ST_PIXEL},
			'{BMP_MAGIC, 32'd40, 32'hFFFF, 16'd24, 32'd0, 32'd54, 40, 6, 0, -9'sd255, 1'b0,
				ST_PIXEL},
			'{BMP_MAGIC, 32'd12, 32'd5, 16'd24, 32'd0, 32'd26, 12, 24, 0, 9'sd37, 1'b0, ST_PIXEL}
		};
		clear_file();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_cases[n]) begin
			wait_for_results();
			set_brightness(dir_cases[n].bright);
			// last three files without random idles or stalls; receiver holds off while the final one keeps coming
			steady = (n >= 10);
			if (n == 12)
				hold_asks++;
			send_file(dir_cases[n]);
		end
		steady = 1'b0;

		start_items = items_sent;
		file_no = 0;
		while (items_sent < start_items + RANDOM_ITEMS) begin
			if (file_no % 2 == 1) begin
				wait_for_results();
				case ($urandom_range(3))
					0: level = 255;
					1: level = -255;
					2: level = 0;
					default: level = int'($urandom_range(0, 510)) - 255;
				endcase
				set_brightness(9'(level));
			end
			send_file(random_case());
			file_no++;
		end

		wait_for_results();
		repeat (16) @(posedge clk);
		$display("Covered %0d files (%0d bytes) over %0d brightness settings; %0d items compared.",
			files_sent, items_sent, settings_used, compared);
		if (errors == 0 && outstanding_bytes.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* bmp24_brightness_stream_core.f */
hw/rtl/bmpbr_pkg.sv
hw/rtl/bmpbr_front.sv
hw/rtl/bmpbr_queue.sv
hw/rtl/bmpbr_back.sv
hw/rtl/bmp24_brightness_stream_core.sv
tb/sv/bmp24_brightness_stream_core_tb.sv
